// ===== src/cpaq_pkg.sv =====
`default_nettype none

package cpaq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned UNITS_W = 16;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned SVC_W   = 33;
  localparam int unsigned OVH_W   = 25;
  localparam int unsigned QLEN_W  = 5;

  // Event codes carried in the result
  localparam logic [1:0] EV_STARTED  = 2'd0;
  localparam logic [1:0] EV_QUEUED   = 2'd1;
  localparam logic [1:0] EV_DONE     = 2'd2;
  localparam logic [1:0] EV_REJECTED = 2'd3;

  // Operation codes of an input item
  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Register indexes (byte address 4*index)
  localparam logic [1:0] REG_TOTAL_CAP  = 2'd0;
  localparam logic [1:0] REG_FAAS_INIT  = 2'd1;
  localparam logic [1:0] REG_CONT_INIT  = 2'd2;
  localparam logic [1:0] REG_FAAS_INST  = 2'd3;

  localparam logic [15:0] RST_TOTAL_CAP = 16'd1024;
  localparam logic [7:0]  RST_FAAS_INST = 8'd1;

  typedef struct packed {
    logic               operation;
    logic [ID_W-1:0]    job_id;
    logic [UNITS_W-1:0] demand;
    logic [DUR_W-1:0]   duration;
    logic               is_faas;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [ID_W-1:0]    out_job_id;
    logic [SVC_W-1:0]   service_time;
    logic               was_waiting;
    logic [UNITS_W-1:0] free_capacity;
    logic [UNITS_W-1:0] jobs_in_system;
    logic [QLEN_W-1:0]  queue_length;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [UNITS_W-1:0] demand;
    logic [DUR_W-1:0]   duration;
    logic               is_faas;
  } wait_entry_t;

  typedef struct packed {
    logic [SVC_W-1:0] a;
    logic [SVC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [SVC_W-1:0] res;
    logic             cout;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/cpaq_alu.sv =====
`default_nettype none

// Shared add/subtract unit; on subtract, cout high means no borrow (a >= b).
module cpaq_alu (
  input  wire cpaq_pkg::alu_req_t req_i,
  output cpaq_pkg::alu_rsp_t      rsp_o
);
  import cpaq_pkg::*;

  logic [SVC_W:0] sum_w;

  assign sum_w = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
               + (SVC_W+1)'(req_i.sub);

  assign rsp_o.res  = sum_w[SVC_W-1:0];
  assign rsp_o.cout = sum_w[SVC_W];

endmodule

`default_nettype wire

// ===== src/cpaq_queue_mem.sv =====
`default_nettype none

// Wait-queue storage: one write port, one registered read port.
module cpaq_queue_mem #(
  parameter  int unsigned DEPTH = cpaq_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [AW-1:0]               waddr_i,
  input  wire  cpaq_pkg::wait_entry_t wdata_i,
  input  wire  [AW-1:0]               raddr_i,
  output cpaq_pkg::wait_entry_t       rdata_o
);
  import cpaq_pkg::*;

  wait_entry_t mem_q [DEPTH];
  wait_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/capacity_pool_admission_queue.sv =====
`default_nettype none

// Channel   | Direction | Handshake                         | Payload
// ----------+-----------+-----------------------------------+------------------
// request   | in        | start high while busy low         | req_i (in_item_t)
// result    | out       | result_strobe_o, one cycle each   | result_o (result_t)
// config    | in/out    | APB write on psel&penable&pwrite  | pwdata / prdata
//
// Steps: an arrival that starts at once does a compare, then the service-time
// add; a queued or rejected arrival only the compare. A completion returns and
// clips capacity, checks the queue head, and per job started from the queue adds
// its service time and checks the head again, all on the single shared adder.
// Reset: rst_ni clears the sequencer, counters and queue pointers at once and
// loads the register reset values; queue memory is not cleared.
// Stalls: the receiver cannot stall; each result transfer lasts one cycle.
module capacity_pool_admission_queue #(
  parameter  int unsigned QUEUE_DEPTH = cpaq_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // request channel
  input  wire                      start,
  output logic                     busy,
  input  wire  cpaq_pkg::in_item_t req_i,
  // result channel
  output logic                     result_strobe_o,
  output cpaq_pkg::result_t        result_o,
  // configuration port
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [3:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import cpaq_pkg::*;

  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ARR  = 7'b0000010,
    S_SVC  = 7'b0000100,
    S_CMP1 = 7'b0001000,
    S_CMP2 = 7'b0010000,
    S_HEAD = 7'b0100000,
    S_QSVC = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] total_q, faas_init_q, cont_init_q;
  logic [7:0]  faas_inst_q;

  // pool state
  logic [UNITS_W-1:0] free_q, free_d;
  logic [UNITS_W-1:0] jobs_q, jobs_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [FW-1:0]      fill_q, fill_d;

  // working registers
  in_item_t        item_q, item_d;
  logic [OVH_W-1:0] ovh_q, ovh_d;
  logic [16:0]     sum_q, sum_d;
  result_t         hold_q, hold_d;
  result_t         res_q, res_d;
  logic            strobe_q, strobe_d;

  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  wait_entry_t     wr_entry, rd_entry;
  logic            mem_we;

  logic [23:0]       faas_prod;
  logic [OVH_W-1:0]  ovh_faas, ovh_cont;
  logic [UNITS_W-1:0] jobs_inc, jobs_dec, free_clip;
  logic              cfg_wr;

  cpaq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  cpaq_queue_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  // Start-up overhead: 2*K*faas_init or 2*container_init
  assign faas_prod = faas_inst_q * faas_init_q;
  assign ovh_faas  = {faas_prod, 1'b0};
  assign ovh_cont  = {8'b0, cont_init_q, 1'b0};

  // Saturating job counter steps
  assign jobs_inc = (jobs_q != '1) ? jobs_q + 1'b1 : jobs_q;
  assign jobs_dec = (jobs_q != '0) ? jobs_q - 1'b1 : jobs_q;

  // Clip returned capacity: cout on sum - total means sum >= total
  assign free_clip = alu_rsp.cout ? total_q : sum_q[UNITS_W-1:0];

  assign wr_entry.job_id   = item_q.job_id;
  assign wr_entry.demand   = item_q.demand;
  assign wr_entry.duration = item_q.duration;
  assign wr_entry.is_faas  = item_q.is_faas;

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_TOTAL_CAP: prdata = {16'b0, total_q};
      REG_FAAS_INIT: prdata = {16'b0, faas_init_q};
      REG_CONT_INIT: prdata = {16'b0, cont_init_q};
      REG_FAAS_INST: prdata = {24'b0, faas_inst_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= RST_TOTAL_CAP;
      faas_init_q <= '0;
      cont_init_q <= '0;
      faas_inst_q <= RST_FAAS_INST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TOTAL_CAP: total_q     <= pwdata[15:0];
        REG_FAAS_INIT: faas_init_q <= pwdata[15:0];
        REG_CONT_INIT: cont_init_q <= pwdata[15:0];
        REG_FAAS_INST: faas_inst_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer around the shared adder
  // ---------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    free_d   = free_q;
    jobs_d   = jobs_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    item_d   = item_q;
    ovh_d    = ovh_q;
    sum_d    = sum_q;
    hold_d   = hold_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    mem_we   = 1'b0;
    alu_req  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d  = req_i;
          state_d = (req_i.operation == OP_COMPLETE) ? S_CMP1 : S_ARR;
        end
      end

      // Arrival: free - demand; start only on a strictly positive difference
      S_ARR: begin
        alu_req.a   = SVC_W'(free_q);
        alu_req.b   = SVC_W'(item_q.demand);
        alu_req.sub = 1'b1;
        ovh_d       = item_q.is_faas ? ovh_faas : ovh_cont;
        res_d.out_job_id   = item_q.job_id;
        res_d.service_time = '0;
        res_d.was_waiting  = 1'b0;
        res_d.last         = 1'b1;
        if (alu_rsp.cout && (alu_rsp.res[UNITS_W-1:0] != '0)) begin
          free_d  = alu_rsp.res[UNITS_W-1:0];
          jobs_d  = jobs_inc;
          state_d = S_SVC;
        end else if (fill_q < FULL_FILL) begin
          // Queue the request at the tail
          mem_we  = 1'b1;
          tail_d  = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
          fill_d  = fill_q + 1'b1;
          jobs_d  = jobs_inc;
          res_d.event_kind     = EV_QUEUED;
          res_d.free_capacity  = free_q;
          res_d.jobs_in_system = jobs_inc;
          res_d.queue_length   = QLEN_W'(fill_q + 1'b1);
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          res_d.event_kind     = EV_REJECTED;
          res_d.free_capacity  = free_q;
          res_d.jobs_in_system = jobs_q;
          res_d.queue_length   = QLEN_W'(fill_q);
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Direct start: service time = duration + overhead
      S_SVC: begin
        alu_req.a   = SVC_W'(item_q.duration);
        alu_req.b   = SVC_W'(ovh_q);
        alu_req.sub = 1'b0;
        res_d.event_kind     = EV_STARTED;
        res_d.out_job_id     = item_q.job_id;
        res_d.service_time   = alu_rsp.res;
        res_d.was_waiting    = 1'b0;
        res_d.free_capacity  = free_q;
        res_d.jobs_in_system = jobs_q;
        res_d.queue_length   = QLEN_W'(fill_q);
        res_d.last           = 1'b1;
        strobe_d = 1'b1;
        state_d  = S_IDLE;
      end

      // Completion: return capacity, then clip to the total
      S_CMP1: begin
        alu_req.a   = SVC_W'(free_q);
        alu_req.b   = SVC_W'(item_q.demand);
        alu_req.sub = 1'b0;
        sum_d   = alu_rsp.res[16:0];
        jobs_d  = jobs_dec;
        state_d = S_CMP2;
      end

      S_CMP2: begin
        alu_req.a   = SVC_W'(sum_q);
        alu_req.b   = SVC_W'(total_q);
        alu_req.sub = 1'b1;
        free_d  = free_clip;
        hold_d.event_kind     = EV_DONE;
        hold_d.out_job_id     = item_q.job_id;
        hold_d.service_time   = '0;
        hold_d.was_waiting    = 1'b0;
        hold_d.free_capacity  = free_clip;
        hold_d.jobs_in_system = jobs_q;
        hold_d.queue_length   = QLEN_W'(fill_q);
        hold_d.last           = 1'b0;
        state_d = S_HEAD;
      end

      // Check the queue head; release the held result once its last flag is known
      S_HEAD: begin
        alu_req.a   = SVC_W'(free_q);
        alu_req.b   = SVC_W'(rd_entry.demand);
        alu_req.sub = 1'b1;
        res_d    = hold_q;
        strobe_d = 1'b1;
        if ((fill_q != '0) && alu_rsp.cout) begin
          res_d.last      = 1'b0;
          free_d          = alu_rsp.res[UNITS_W-1:0];
          head_d          = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
          fill_d          = fill_q - 1'b1;
          item_d.job_id   = rd_entry.job_id;
          item_d.duration = rd_entry.duration;
          item_d.is_faas  = rd_entry.is_faas;
          ovh_d           = rd_entry.is_faas ? ovh_faas : ovh_cont;
          state_d         = S_QSVC;
        end else begin
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Start from the queue: build the held result, go back to the head check
      S_QSVC: begin
        alu_req.a   = SVC_W'(item_q.duration);
        alu_req.b   = SVC_W'(ovh_q);
        alu_req.sub = 1'b0;
        hold_d.event_kind     = EV_STARTED;
        hold_d.out_job_id     = item_q.job_id;
        hold_d.service_time   = alu_rsp.res;
        hold_d.was_waiting    = 1'b1;
        hold_d.free_capacity  = free_q;
        hold_d.jobs_in_system = jobs_q;
        hold_d.queue_length   = QLEN_W'(fill_q);
        hold_d.last           = 1'b0;
        state_d = S_HEAD;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      free_q   <= RST_TOTAL_CAP;
      jobs_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      jobs_q   <= jobs_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ovh_q  <= ovh_d;
    sum_q  <= sum_d;
    hold_q <= hold_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cpaq_pkg::*;

  localparam int unsigned QDEPTH      = DEFAULT_QUEUE_DEPTH;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          RANDOM_PER_PHASE = 95;

  // A job that holds capacity in the pool; the stimulus completes these.
  typedef struct {
    logic [ID_W-1:0]    id;
    logic [UNITS_W-1:0] units;
  } live_job_t;

  // One row of the directed plan. Rows with typed set carry the event kind of
  // their first result, written in by hand.
  typedef struct {
    logic               op;
    logic [ID_W-1:0]    id;
    logic [UNITS_W-1:0] units;
    logic [DUR_W-1:0]   ticks;
    logic               faas;
    bit                 typed;
    logic [1:0]         kind;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    req_i;
  logic        result_strobe_o;
  result_t     result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  capacity_pool_admission_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_i           (req_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Register copies kept by the predictor.
  logic [UNITS_W-1:0] cfg_total;
  logic [15:0]        cfg_faas_init;
  logic [15:0]        cfg_cont_init;
  logic [7:0]         cfg_faas_inst;

  // Pool state as the predictor sees it.
  logic [UNITS_W-1:0] pool_free;
  logic [UNITS_W-1:0] jobs_live;
  wait_entry_t        wait_line [QDEPTH];
  int unsigned        wait_head;
  int unsigned        wait_fill;

  result_t            awaited_events [$];
  live_job_t          running_jobs [$];
  int                 mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a transfer.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Start-up overhead: 2*K*faas_init for function jobs, 2*container_init else.
  function automatic logic [SVC_W-1:0] service_ticks(logic [DUR_W-1:0] dur, logic faas);
    longint unsigned overhead;
    if (faas) begin
      overhead = 64'd2 * 64'(cfg_faas_inst) * 64'(cfg_faas_init);
    end else begin
      overhead = 64'd2 * 64'(cfg_cont_init);
    end
    return SVC_W'(64'(dur) + overhead);
  endfunction

  // Record one result with the pool state as it stands right now.
  task automatic note_event(logic [1:0] kind, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc,
                            logic waited);
    result_t ev;
    ev.event_kind     = kind;
    ev.out_job_id     = id;
    ev.service_time   = svc;
    ev.was_waiting    = waited;
    ev.free_capacity  = pool_free;
    ev.jobs_in_system = jobs_live;
    ev.queue_length   = QLEN_W'(wait_fill);
    ev.last           = 1'b0;
    awaited_events.push_back(ev);
  endtask

  // Apply one accepted request to the pool and queue up the results it causes.
  task automatic admit_or_release(in_item_t item, bit typed, logic [1:0] typed_kind);
    int unsigned first;
    int unsigned slot;
    int unsigned refill;
    wait_entry_t head;
    result_t     ev;
    first = awaited_events.size();
    if (item.operation == OP_ARRIVE) begin
      if (pool_free > item.demand) begin
        // strictly more free than asked: start now, even past waiting jobs
        pool_free = pool_free - item.demand;
        if (jobs_live != '1) jobs_live = jobs_live + 1'b1;
        running_jobs.push_back('{item.job_id, item.demand});
        note_event(EV_STARTED, item.job_id, service_ticks(item.duration, item.is_faas), 1'b0);
      end else if (wait_fill < QDEPTH) begin
        slot = (wait_head + wait_fill) % QDEPTH;
        wait_line[slot] = '{item.job_id, item.demand, item.duration, item.is_faas};
        wait_fill++;
        if (jobs_live != '1) jobs_live = jobs_live + 1'b1;
        note_event(EV_QUEUED, item.job_id, '0, 1'b0);
      end else begin
        // queue full: nothing changes
        note_event(EV_REJECTED, item.job_id, '0, 1'b0);
      end
    end else begin
      // return capacity, clipped to the current total
      refill = int'(pool_free) + int'(item.demand);
      if (refill > int'(cfg_total)) refill = cfg_total;
      pool_free = UNITS_W'(refill);
      if (jobs_live != '0) jobs_live = jobs_live - 1'b1;
      note_event(EV_DONE, item.job_id, '0, 1'b0);
      // drain the head while it fits (here "at least" suffices)
      while (wait_fill > 0 && pool_free >= wait_line[wait_head].demand) begin
        head = wait_line[wait_head];
        pool_free = pool_free - head.demand;
        wait_head = (wait_head + 1) % QDEPTH;
        wait_fill--;
        running_jobs.push_back('{head.job_id, head.demand});
        note_event(EV_STARTED, head.job_id, service_ticks(head.duration, head.is_faas), 1'b1);
      end
    end
    ev = awaited_events[awaited_events.size() - 1];
    ev.last = 1'b1;
    awaited_events[awaited_events.size() - 1] = ev;
    if (typed) begin
      ev = awaited_events[first];
      ev.event_kind = typed_kind;
      awaited_events[first] = ev;
    end
  endtask

  // Entered at a falling edge; hold start until the transfer, then predict.
  // Returns at the falling edge after the transfer with start still high.
  task automatic push_request(in_item_t item, bit typed, logic [1:0] typed_kind);
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    admit_or_release(item, typed, typed_kind);
    @(negedge clk_i);
  endtask

  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop start and wait until every result is in and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (awaited_events.size() != 0 || busy);
  endtask

  // Write a register, read it back, and update the predictor's copy.
  task automatic write_register(logic [1:0] index, logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      REG_TOTAL_CAP: cfg_total     = value[15:0];
      REG_FAAS_INIT: cfg_faas_init = value[15:0];
      REG_CONT_INIT: cfg_cont_init = value[15:0];
      REG_FAAS_INST: cfg_faas_inst = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      REG_TOTAL_CAP: readback = 32'(cfg_total);
      REG_FAAS_INIT: readback = 32'(cfg_faas_init);
      REG_CONT_INIT: readback = 32'(cfg_cont_init);
      default:       readback = 32'(cfg_faas_inst);
    endcase
    if (prdata !== readback) begin
      $error("prdata[%0d]: expected %0h, got %0h", index, readback, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_strobe_o) begin
      if (awaited_events.size() == 0) begin
        $error("result with nothing awaited: kind %0d id %0h",
               result_o.event_kind, result_o.out_job_id);
        mismatch_count++;
      end else begin
        want = awaited_events.pop_front();
        check_field("event_kind",     want.event_kind,     result_o.event_kind);
        check_field("out_job_id",     want.out_job_id,     result_o.out_job_id);
        check_field("service_time",   want.service_time,   result_o.service_time);
        check_field("was_waiting",    want.was_waiting,    result_o.was_waiting);
        check_field("free_capacity",  want.free_capacity,  result_o.free_capacity);
        check_field("jobs_in_system", want.jobs_in_system, result_o.jobs_in_system);
        check_field("queue_length",   want.queue_length,   result_o.queue_length);
        check_field("last",           want.last,           result_o.last);
      end
    end
  end

  initial begin
    plan_row_t   plan [24];
    in_item_t    item;
    int          row;
    int          phase;
    int          n;
    int          pick;
    int          slot;
    int          idle_pct;
    logic [31:0] set_total;
    logic [31:0] set_faas;
    logic [31:0] set_cont;
    logic [31:0] set_inst;

    // Hold every input at a known value from time zero.
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    mismatch_count = 0;

    cfg_total     = RST_TOTAL_CAP;
    cfg_faas_init = '0;
    cfg_cont_init = '0;
    cfg_faas_inst = RST_FAAS_INST;
    pool_free     = RST_TOTAL_CAP;
    jobs_live     = '0;
    wait_head     = 0;
    wait_fill     = 0;

    // Directed plan, from reset (pool of 1024, no start-up overhead):
    // zero demand starts; demand equal to free capacity has to wait; a request
    // that fits starts past a waiting one; an oversized completion saturates
    // the pool and starts the head; then fill the queue, overflow it, and drain
    // all sixteen in one completion.
    plan[0]  = '{OP_ARRIVE,   16'h0000, 16'd0,    32'h0000_0000, 1'b0, 1'b1, EV_STARTED};
    plan[1]  = '{OP_ARRIVE,   16'h1111, 16'd1024, 32'h0000_0001, 1'b1, 1'b1, EV_QUEUED};
    plan[2]  = '{OP_ARRIVE,   16'hFFFF, 16'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_STARTED};
    plan[3]  = '{OP_COMPLETE, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b0, 1'b1, EV_DONE};
    for (row = 0; row < 16; row++) begin
      plan[4 + row] = '{OP_ARRIVE, 16'h0100 + 16'(row), 16'(row + 1), $urandom,
                        1'(row), 1'b1, EV_QUEUED};
    end
    plan[20] = '{OP_ARRIVE,   16'hABCD, 16'd0,    32'h8000_0000, 1'b0, 1'b1, EV_REJECTED};
    plan[21] = '{OP_COMPLETE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_DONE};
    plan[22] = '{OP_ARRIVE,   16'h5A5A, 16'hFFFF, 32'hAAAA_5555, 1'b1, 1'b0, EV_QUEUED};
    plan[23] = '{OP_COMPLETE, 16'h1234, 16'd0,    32'h5555_AAAA, 1'b0, 1'b0, EV_DONE};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < 24; row++) begin
      item.operation = plan[row].op;
      item.job_id    = plan[row].id;
      item.demand    = plan[row].units;
      item.duration  = plan[row].ticks;
      item.is_faas   = plan[row].faas;
      push_request(item, plan[row].typed, plan[row].kind);
    end
    wait_drained();

    // Random phases, each behind a register update on an idle block.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          // small pool, modest overheads
          set_total = {16'($urandom), 16'($urandom_range(24, 200))};
          set_faas  = {16'($urandom), 16'($urandom_range(0, 300))};
          set_cont  = {16'($urandom), 16'($urandom_range(0, 300))};
          set_inst  = {24'($urandom), 8'($urandom_range(1, 8))};
          idle_pct  = 23;
        end
        1: begin
          // every register at its top value
          set_total = {16'($urandom), 16'hFFFF};
          set_faas  = {16'($urandom), 16'hFFFF};
          set_cont  = {16'($urandom), 16'hFFFF};
          set_inst  = {24'($urandom), 8'hFF};
          idle_pct  = 23;
        end
        2: begin
          // a one-unit pool with no overhead; free capacity clips on completion
          set_total = {16'($urandom), 16'd1};
          set_faas  = {16'($urandom), 16'd0};
          set_cont  = {16'($urandom), 16'd0};
          set_inst  = {24'($urandom), 8'd1};
          idle_pct  = 68;
        end
        default: begin
          set_total = {16'($urandom), 16'($urandom_range(1, 65535))};
          set_faas  = $urandom;
          set_cont  = $urandom;
          set_inst  = {24'($urandom), 8'($urandom_range(1, 255))};
          idle_pct  = 0;
        end
      endcase
      write_register(REG_TOTAL_CAP, set_total);
      write_register(REG_FAAS_INIT, set_faas);
      write_register(REG_CONT_INIT, set_cont);
      write_register(REG_FAAS_INST, set_inst);

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        item.job_id   = 16'($urandom);
        item.demand   = 16'($urandom);
        item.duration = $urandom;
        item.is_faas  = 1'($urandom);
        if (pick < 35 && running_jobs.size() != 0) begin
          // well-formed completion: release what a running job holds
          slot = $urandom_range(running_jobs.size() - 1);
          item.operation = OP_COMPLETE;
          item.job_id    = running_jobs[slot].id;
          item.demand    = running_jobs[slot].units;
          running_jobs.delete(slot);
        end else if (pick < 42) begin
          // stray completion with arbitrary demand
          item.operation = OP_COMPLETE;
          if (pick < 37) item.demand = '0;
        end else begin
          item.operation = OP_ARRIVE;
          case ($urandom_range(9))
            6: item.demand = cfg_total;
            7: item.demand = cfg_total - 1'b1;
            8: item.demand = '0;
            9: ;
            default: item.demand = 16'($urandom_range(0, int'(cfg_total) / 3 + 1));
          endcase
          if (pick > 95) item.duration = '1;
          else if (pick < 46) item.duration = '0;
        end
        push_request(item, 1'b0, EV_STARTED);
        if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, 6));
      end
      // pause the sender until the phase is fully answered
      wait_drained();
    end

    // let any stray transfer show up before the verdict
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && awaited_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
